// ===== hdl/cle_pkg.sv =====
package cle_pkg;

  // control key codes
  localparam logic [7:0] KEY_KILL  = 8'h15;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_DEL   = 8'h7f;
  localparam logic [7:0] KEY_TASKS = 8'h10;
  localparam logic [7:0] KEY_EOF   = 8'h04;
  localparam logic [7:0] KEY_CR    = 8'h0d;
  localparam logic [7:0] KEY_NL    = 8'h0a;
  localparam logic [7:0] KEY_NUL   = 8'h00;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic walk;
    logic finish;
    logic out_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_kill;
    logic walk_done;
  } status_t;

  // one result item
  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic [7:0] erase_count;
    logic       show_tasks;
    logic       read_valid;
    logic [7:0] read_char;
    logic       read_empty;
    logic       read_eof;
    logic       read_stop;
    logic       line_end;
  } result_t;

endpackage

// ===== hdl/console_line_editor_core.sv =====
// Console line editor core: canonical line editing over a ring of BUF_DEPTH bytes.
// Input channel (in_valid / in_stall) carries one item: operation 0 is a received
// key in key_char, operation 1 asks for one committed byte, read_start marking the
// first request of a read call. Output channel (out_valid / out_stall) returns
// exactly one result item per input item, in order.
// An accepted item passes through state EXEC, where a line kill walks back over up to
// BUF_DEPTH - 1 erased characters one at a time, reading the line store once a cycle
// through its single read port, then state DONE, which loads the output register.
// A new item is taken only after the previous one has left DONE.
// The next item is taken while the previous result still waits in the output
// register; if the receiver keeps stalling, the finished result of that next item
// waits inside and in_stall stays high until the output register frees.
// Reset (rst, synchronous) empties the ring: read, commit and edit indices go to
// zero and no result is pending. The line store itself needs no clearing.
module console_line_editor_core #(
  parameter int BUF_DEPTH = 128
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       operation,
  input  logic [7:0] key_char,
  input  logic       read_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       echo_valid,
  output logic [7:0] echo_char,
  output logic [7:0] erase_count,
  output logic       show_tasks,
  output logic       read_valid,
  output logic [7:0] read_char,
  output logic       read_empty,
  output logic       read_eof,
  output logic       read_stop,
  output logic       line_end
);

  cle_pkg::cmd_t    cmd;
  cle_pkg::status_t sts;
  cle_pkg::result_t result;

  // sequencing
  cle_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // ring, indices and result registers
  cle_datapath #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .operation  (operation),
    .key_char   (key_char),
    .read_start (read_start),
    .cmd        (cmd),
    .sts        (sts),
    .result     (result)
  );

  // result fields to ports
  assign echo_valid  = result.echo_valid;
  assign echo_char   = result.echo_char;
  assign erase_count = result.erase_count;
  assign show_tasks  = result.show_tasks;
  assign read_valid  = result.read_valid;
  assign read_char   = result.read_char;
  assign read_empty  = result.read_empty;
  assign read_eof    = result.read_eof;
  assign read_stop   = result.read_stop;
  assign line_end    = result.line_end;

endmodule

// ===== hdl/cle_controller.sv =====
module cle_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  cle_pkg::status_t  sts,
  output cle_pkg::cmd_t     cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       out_free;

  // output register can take a new item
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_kill && !sts.walk_done) begin
          cmd.walk = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result loaded while output still stalled");

  // one item at a time
  a_load_then_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> in_stall && !cmd.load)
    else $error("item accepted while previous item in progress");

  // an item finishes once
  a_single_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> !cmd.finish && !cmd.walk)
    else $error("item finished twice or walk after finish");

endmodule

// ===== hdl/cle_datapath.sv =====
module cle_datapath #(
  parameter int BUF_DEPTH = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              operation,
  input  logic [7:0]        key_char,
  input  logic              read_start,
  input  cle_pkg::cmd_t     cmd,
  output cle_pkg::status_t  sts,
  output cle_pkg::result_t  result
);

  localparam int IDX_MOD = 2 * BUF_DEPTH;
  localparam int IW      = $clog2(IDX_MOD);
  localparam int SW      = $clog2(BUF_DEPTH);
  localparam int CW      = $clog2(BUF_DEPTH + 1);
  localparam logic [IW-1:0] IDX_LAST = IW'(IDX_MOD - 1);
  localparam logic [IW-1:0] IDX_MODV = IW'(IDX_MOD);
  localparam logic [IW-1:0] DEPTH_I  = IW'(BUF_DEPTH);
  localparam logic [IW-1:0] DEPTH_M1 = IW'(BUF_DEPTH - 1);

  // ring index helpers, indices run modulo twice the depth
  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
    return (a == IDX_LAST) ? '0 : a + IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
    return (a == '0) ? IDX_LAST : a - IW'(1);
  endfunction

  function automatic logic [IW-1:0] idx_sub(input logic [IW-1:0] a, input logic [IW-1:0] b);
    return (a >= b) ? a - b : a - b + IDX_MODV;
  endfunction

  function automatic logic [SW-1:0] slot(input logic [IW-1:0] a);
    logic [IW-1:0] t;
    t = (a >= DEPTH_I) ? a - DEPTH_I : a;
    return t[SW-1:0];
  endfunction

  logic [7:0]    line_store [BUF_DEPTH];
  logic [7:0]    rd_data;
  logic [SW-1:0] rd_slot;
  logic [SW-1:0] wr_slot;
  logic          wr_en;
  logic [7:0]    store_char;

  logic          op;
  logic [7:0]    key;
  logic          first;
  logic [IW-1:0] read_index;
  logic [IW-1:0] commit_index;
  logic [IW-1:0] edit_index;
  logic [IW-1:0] read_index_next;
  logic [IW-1:0] commit_index_next;
  logic [IW-1:0] edit_index_next;
  logic [IW-1:0] edit_inc;
  logic [IW-1:0] fill;
  logic [CW-1:0] kill_count;
  cle_pkg::result_t res;
  cle_pkg::result_t res_next;

  // read address: popped byte or char before edit point, one step ahead during walk
  always_comb begin
    if (cmd.load) begin
      rd_slot = operation ? slot(read_index) : slot(idx_dec(edit_index));
    end else begin
      rd_slot = slot(idx_dec(idx_dec(edit_index)));
    end
  end

  assign store_char = (key == cle_pkg::KEY_CR) ? cle_pkg::KEY_NL : key;
  assign wr_slot    = slot(edit_index);
  assign edit_inc   = idx_inc(edit_index);
  assign fill       = idx_sub(edit_index, read_index);

  // status for the controller
  assign sts.is_kill   = !op && (key == cle_pkg::KEY_KILL);
  assign sts.walk_done = (edit_index == commit_index) || (rd_data == cle_pkg::KEY_NL);

  // item execution
  always_comb begin
    read_index_next   = read_index;
    commit_index_next = commit_index;
    edit_index_next   = edit_index;
    res_next          = '0;
    wr_en             = 1'b0;
    if (cmd.walk) begin
      edit_index_next = idx_dec(edit_index);
    end
    if (cmd.finish) begin
      if (!op) begin
        if (key == cle_pkg::KEY_KILL) begin
          res_next.erase_count = 8'(kill_count);
        end else if (key == cle_pkg::KEY_BS || key == cle_pkg::KEY_DEL) begin
          if (edit_index != commit_index) begin
            edit_index_next      = idx_dec(edit_index);
            res_next.erase_count = 8'd1;
          end
        end else if (key == cle_pkg::KEY_TASKS) begin
          res_next.show_tasks = 1'b1;
        end else if (key != cle_pkg::KEY_NUL && fill < DEPTH_I) begin
          res_next.echo_valid = 1'b1;
          res_next.echo_char  = store_char;
          wr_en               = 1'b1;
          edit_index_next     = edit_inc;
          if (store_char == cle_pkg::KEY_NL || store_char == cle_pkg::KEY_EOF ||
              fill == DEPTH_M1) begin
            commit_index_next = edit_inc;
          end
        end
      end else begin
        if (read_index == commit_index) begin
          res_next.read_empty = 1'b1;
        end else if (rd_data == cle_pkg::KEY_EOF) begin
          if (first) begin
            read_index_next   = idx_inc(read_index);
            res_next.read_eof = 1'b1;
          end else begin
            res_next.read_stop = 1'b1;
          end
        end else begin
          read_index_next     = idx_inc(read_index);
          res_next.read_valid = 1'b1;
          res_next.read_char  = rd_data;
          res_next.line_end   = (rd_data == cle_pkg::KEY_NL);
        end
      end
    end
  end

  // line store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[wr_slot] <= store_char;
    end
    rd_data <= line_store[rd_slot];
  end

  // ring indices
  always_ff @(posedge clk) begin
    if (rst) begin
      read_index   <= '0;
      commit_index <= '0;
      edit_index   <= '0;
    end else begin
      read_index   <= read_index_next;
      commit_index <= commit_index_next;
      edit_index   <= edit_index_next;
    end
  end

  // item latch, erase counter, result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= operation;
      key   <= key_char;
      first <= read_start;
    end
    if (cmd.load) begin
      kill_count <= '0;
    end else if (cmd.walk) begin
      kill_count <= kill_count + CW'(1);
    end
    if (cmd.finish) begin
      res <= res_next;
    end
    if (cmd.out_load) begin
      result <= res;
    end
  end

  // ring never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    idx_sub(edit_index, read_index) <= DEPTH_I)
    else $error("ring overfilled");

  // committed end lies between read and edit points
  a_commit_order: assert property (@(posedge clk) disable iff (rst)
    idx_sub(commit_index, read_index) <= idx_sub(edit_index, read_index))
    else $error("commit index outside read..edit span");

endmodule
